>>> hdl/rti_pkg.sv
// Shared types, widths and helpers for the ray/triangle intersection core.
// No dependencies; every module of the core imports this package.
package rti_pkg;

  // Component format and derived datapath widths
  localparam int CompBits = 21;
  localparam int DirFrac  = CompBits - 2;
  localparam int VecW     = 63;
  localparam int EW       = CompBits + 1;
  localparam int PW       = 2 * CompBits + 2;
  localparam int QW       = 2 * CompBits + 3;
  localparam int DotW     = 3 * CompBits + 6;
  localparam int TW       = 32;
  localparam int RemW     = DotW + TW;
  localparam int ThrW     = 32;

  localparam logic [ThrW-1:0] ThrReset = 32'd54975581;

  typedef logic signed [CompBits-1:0] comp_t;
  typedef logic signed [EW-1:0]       evec_t [3];
  typedef logic signed [CompBits-1:0] dvec_t [3];
  typedef logic signed [PW-1:0]       pvec_t [3];
  typedef logic signed [QW-1:0]       qvec_t [3];
  typedef logic signed [DotW-1:0]     dot_t;

  // Item handed from the test stage to the divider
  typedef struct packed {
    logic            vld;
    logic            hit;
    logic            neg;
    logic [DotW-1:0] det;
    logic [RemW-1:0] num;
  } div_in_t;

  // Pick component i out of a packed vector
  function automatic comp_t comp_sel(input logic [VecW-1:0] v, input int i);
    return v[i*CompBits +: CompBits];
  endfunction

  // Difference of two components, one bit wider
  function automatic logic signed [EW-1:0] comp_sub(input comp_t x, input comp_t y);
    return EW'(x) - EW'(y);
  endfunction

endpackage

>>> hdl/rti_front.sv
// Front end: unpack, edge vectors (stage 1) and cross products (stage 2).
// Depends on rti_pkg.
module rti_front import rti_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  logic [VecW-1:0] orig,
  input  logic [VecW-1:0] dir,
  input  logic [VecW-1:0] va,
  input  logic [VecW-1:0] vb,
  input  logic [VecW-1:0] vc,
  output logic            vld_o,
  output evec_t           e1_o,
  output evec_t           e2_o,
  output evec_t           s_o,
  output dvec_t           d_o,
  output pvec_t           p_o,
  output qvec_t           q_o
);

  logic  vld1_r, vld2_r;
  evec_t e1_r, e2_r, s_r, e1b_r, e2b_r, sb_r;
  dvec_t d_r, db_r;
  pvec_t p_r, p_nxt;
  qvec_t q_r, q_nxt;
  evec_t e1_nxt, e2_nxt, s_nxt;
  dvec_t d_nxt;

  // Stage 1: unpack and subtract vertex A
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = comp_sub(comp_sel(vb, i), comp_sel(va, i));
      e2_nxt[i] = comp_sub(comp_sel(vc, i), comp_sel(va, i));
      s_nxt[i]  = comp_sub(comp_sel(orig, i), comp_sel(va, i));
      d_nxt[i]  = comp_sel(dir, i);
    end
  end

  // Stage 2: p = d x e2, q = s x e1
  always_comb begin
    p_nxt[0] = PW'(d_r[1]) * PW'(e2_r[2]) - PW'(d_r[2]) * PW'(e2_r[1]);
    p_nxt[1] = PW'(d_r[2]) * PW'(e2_r[0]) - PW'(d_r[0]) * PW'(e2_r[2]);
    p_nxt[2] = PW'(d_r[0]) * PW'(e2_r[1]) - PW'(d_r[1]) * PW'(e2_r[0]);
    q_nxt[0] = QW'(s_r[1]) * QW'(e1_r[2]) - QW'(s_r[2]) * QW'(e1_r[1]);
    q_nxt[1] = QW'(s_r[2]) * QW'(e1_r[0]) - QW'(s_r[0]) * QW'(e1_r[2]);
    q_nxt[2] = QW'(s_r[0]) * QW'(e1_r[1]) - QW'(s_r[1]) * QW'(e1_r[0]);
  end

  // Advance both stages together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r  <= e1_nxt;
      e2_r  <= e2_nxt;
      s_r   <= s_nxt;
      d_r   <= d_nxt;
      p_r   <= p_nxt;
      q_r   <= q_nxt;
      e1b_r <= e1_r;
      e2b_r <= e2_r;
      sb_r  <= s_r;
      db_r  <= d_r;
    end
  end

  assign vld_o = vld2_r;
  assign e1_o  = e1b_r;
  assign e2_o  = e2b_r;
  assign s_o   = sb_r;
  assign d_o   = db_r;
  assign p_o   = p_r;
  assign q_o   = q_r;

endmodule

>>> hdl/rti_dot.sv
// Dot products (stages 3 and 4) and hit tests with sign fold (stage 5).
// Depends on rti_pkg.
module rti_dot import rti_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic [ThrW-1:0] thr,
  input  logic            vld_i,
  input  evec_t           e1_i,
  input  evec_t           e2_i,
  input  evec_t           s_i,
  input  dvec_t           d_i,
  input  pvec_t           p_i,
  input  qvec_t           q_i,
  output div_in_t         div_o
);

  logic    vld3_r, vld4_r;
  dot_t    det_pr_r [3];
  dot_t    un_pr_r  [3];
  dot_t    vn_pr_r  [3];
  dot_t    tn_pr_r  [3];
  dot_t    det_r, un_r, vn_r, tn_r;
  div_in_t div_r, div_nxt;

  dot_t                   det_n, un_n, vn_n, tn_n, t_abs;
  logic                   flip;
  logic signed [DotW:0]   u_rem;
  logic signed [DotW+1:0] v_rem;
  logic                   thr_ok, u_ok, v_ok;

  // Stage 5: fold the determinant sign, run the tests, scale |tn|
  always_comb begin
    flip   = det_r[DotW-1];
    det_n  = flip ? -det_r : det_r;
    un_n   = flip ? -un_r  : un_r;
    vn_n   = flip ? -vn_r  : vn_r;
    tn_n   = flip ? -tn_r  : tn_r;
    thr_ok = $unsigned(det_n) >= DotW'(thr);
    u_rem  = (DotW+1)'(det_n) - (DotW+1)'(un_n);
    v_rem  = (DotW+2)'(det_n) - (DotW+2)'(un_n) - (DotW+2)'(vn_n);
    u_ok   = !un_n[DotW-1] && !u_rem[DotW];
    v_ok   = !vn_n[DotW-1] && !v_rem[DotW+1];
    t_abs  = tn_n[DotW-1] ? -tn_n : tn_n;
    div_nxt.vld = vld4_r;
    div_nxt.hit = (det_n != '0) && thr_ok && u_ok && v_ok;
    div_nxt.neg = tn_n[DotW-1];
    div_nxt.det = det_n;
    div_nxt.num = RemW'($unsigned(t_abs)) << DirFrac;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r    <= 1'b0;
      vld4_r    <= 1'b0;
      div_r.vld <= 1'b0;
    end else if (adv) begin
      vld3_r <= vld_i;
      vld4_r <= vld3_r;
      div_r  <= div_nxt;
    end
  end

  // Stage 3: component products; stage 4: sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        det_pr_r[i] <= DotW'(e1_i[i]) * DotW'(p_i[i]);
        un_pr_r[i]  <= DotW'(s_i[i])  * DotW'(p_i[i]);
        vn_pr_r[i]  <= DotW'(d_i[i])  * DotW'(q_i[i]);
        tn_pr_r[i]  <= DotW'(e2_i[i]) * DotW'(q_i[i]);
      end
      det_r <= det_pr_r[0] + det_pr_r[1] + det_pr_r[2];
      un_r  <= un_pr_r[0]  + un_pr_r[1]  + un_pr_r[2];
      vn_r  <= vn_pr_r[0]  + vn_pr_r[1]  + vn_pr_r[2];
      tn_r  <= tn_pr_r[0]  + tn_pr_r[1]  + tn_pr_r[2];
    end
  end

  assign div_o = div_r;

endmodule

>>> hdl/rti_div.sv
// Pipelined restoring divider for the hit distance, one quotient bit per stage,
// plus sign and saturation of the result. Depends on rti_pkg.
module rti_div import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  div_in_t              div_i,
  output logic                 vld_o,
  output logic                 hit_o,
  output logic signed [TW-1:0] dist_o
);

  typedef struct packed {
    logic            vld;
    logic            hit;
    logic            neg;
    logic [DotW-1:0] det;
    logic [RemW-1:0] rem;
    logic [TW-1:0]   quo;
  } dstg_t;

  dstg_t stg_in  [TW];
  dstg_t stg_nxt [TW];
  dstg_t stg_r   [TW];

  logic [TW-1:0] mag;

  assign stg_in[0] = '{vld: div_i.vld, hit: div_i.hit, neg: div_i.neg,
                       det: div_i.det, rem: div_i.num, quo: '0};

  for (genvar g = 0; g < TW; g++) begin : g_step
    logic [RemW-1:0] sh;
    logic            ge;

    if (g > 0) begin : g_link
      assign stg_in[g] = stg_r[g-1];
    end

    // Try to subtract det shifted to this quotient bit
    always_comb begin
      sh          = RemW'(stg_in[g].det) << (TW - 1 - g);
      ge          = stg_in[g].rem >= sh;
      stg_nxt[g]  = stg_in[g];
      if (ge) begin
        stg_nxt[g].rem = stg_in[g].rem - sh;
      end
      stg_nxt[g].quo[TW-1-g] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[g].vld <= 1'b0;
      end else if (adv) begin
        stg_r[g] <= stg_nxt[g];
      end
    end
  end

  // Top quotient bit set means the quotient reached 2^31: saturate
  always_comb begin
    mag = stg_r[TW-1].quo[TW-1] ? {1'b1, {(TW-1){1'b0}}} : stg_r[TW-1].quo;
    if (!stg_r[TW-1].hit) begin
      dist_o = '0;
    end else if (stg_r[TW-1].neg) begin
      dist_o = -$signed(mag);
    end else if (mag[TW-1]) begin
      dist_o = {1'b0, {(TW-1){1'b1}}};
    end else begin
      dist_o = $signed(mag);
    end
  end

  assign vld_o = stg_r[TW-1].vld;
  assign hit_o = stg_r[TW-1].hit;

endmodule

>>> hdl/ray_triangle_intersect_core.sv
// Top level of the ray/triangle intersection core: threshold register,
// stall control and output register. Depends on rti_pkg, rti_front, rti_dot, rti_div.

// Moller-Trumbore ray/triangle test in exact fixed point. One ray/triangle pair
// is taken per cycle unless the pipe stalls; each passes 2 stages of edge and
// cross products, 3 of dot products and tests, 32 of the divider that forms the
// distance one quotient bit per stage, and the output register. The whole pipe
// advances together; it stalls only when the output register holds an untaken
// result. A miss reports hit = 0 with distance 0. The user must write the
// threshold via cfg_wr_en/cfg_wr_data only while the core is idle; not enforced.
module ray_triangle_intersect_core import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VecW-1:0]      in_ray_origin_packed,
  input  logic [VecW-1:0]      in_ray_dir_packed,
  input  logic [VecW-1:0]      in_vertex_a_packed,
  input  logic [VecW-1:0]      in_vertex_b_packed,
  input  logic [VecW-1:0]      in_vertex_c_packed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic signed [TW-1:0] out_distance,
  input  logic                 cfg_wr_en,
  input  logic [ThrW-1:0]      cfg_wr_data
);

  logic                 adv;
  logic [ThrW-1:0]      thr_r;
  logic                 out_vld_r, out_hit_r;
  logic signed [TW-1:0] out_dist_r;

  logic    fr_vld;
  evec_t   fr_e1, fr_e2, fr_s;
  dvec_t   fr_d;
  pvec_t   fr_p;
  qvec_t   fr_q;
  div_in_t dv_in;
  logic    dv_vld, dv_hit;
  logic signed [TW-1:0] dv_dist;

  // Advance the pipe unless the output holds an untaken result
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  // Hold the parallel threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThrReset;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  rti_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .orig   (in_ray_origin_packed),
    .dir    (in_ray_dir_packed),
    .va     (in_vertex_a_packed),
    .vb     (in_vertex_b_packed),
    .vc     (in_vertex_c_packed),
    .vld_o  (fr_vld),
    .e1_o   (fr_e1),
    .e2_o   (fr_e2),
    .s_o    (fr_s),
    .d_o    (fr_d),
    .p_o    (fr_p),
    .q_o    (fr_q)
  );

  rti_dot u_dot (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .thr   (thr_r),
    .vld_i (fr_vld),
    .e1_i  (fr_e1),
    .e2_i  (fr_e2),
    .s_i   (fr_s),
    .d_i   (fr_d),
    .p_i   (fr_p),
    .q_i   (fr_q),
    .div_o (dv_in)
  );

  rti_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .div_i  (dv_in),
    .vld_o  (dv_vld),
    .hit_o  (dv_hit),
    .dist_o (dv_dist)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r  <= dv_hit;
      out_dist_r <= dv_dist;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_dist_r;

endmodule
